FILE: sv/pad_trigger_router_unit_defines.svh
// ----------------------------------------------------------------------------
// pad_trigger_router_unit_defines.svh
// Assertion macros shared by the pad trigger router RTL.
// ----------------------------------------------------------------------------
`ifndef PAD_TRIGGER_ROUTER_UNIT_DEFINES_SVH
`define PAD_TRIGGER_ROUTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define PTR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define PTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ptr_pkg.sv
// ----------------------------------------------------------------------------
// ptr_pkg
// Types, field widths and codes for the pad trigger router.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptr_pkg;

    // Field widths of the request and result beats and the config registers
    localparam int MASK_W     = 16;
    localparam int NOTE_W     = 7;
    localparam int SLOT_W     = 4;
    localparam int NSAMP_W    = 16;
    localparam int ACT_W      = 2;
    localparam int LEN_W      = 24;
    localparam int REQ_W      = 3;
    localparam int MODE_W     = 2;
    localparam int GROUP_W    = 4;
    localparam int EXP_W      = 24;
    localparam int MODES_W    = 32;
    localparam int GROUPS_W   = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Parameter defaults
    localparam int DEF_NUM_SLOTS  = 16;
    localparam int DEF_COUNT_BITS = 24;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_NOTE_ON     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_NOTE_OFF    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PREVIEW_ON  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PREVIEW_OFF = 3'd3;
    localparam logic [REQ_W-1:0] REQ_ADVANCE     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_STOP        = 3'd5;
    localparam logic [REQ_W-1:0] REQ_PANIC       = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SET_FOCUS   = 3'd7;

    // Transport stop actions
    localparam logic [ACT_W-1:0] STOP_KILL    = 2'd1;
    localparam logic [ACT_W-1:0] STOP_RELEASE = 2'd2;

    // Trigger modes
    localparam logic [MODE_W-1:0] MODE_GATE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LATCH    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ONESHOT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_NOTE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHOKE_GROUPS  = 2'd2;

    localparam logic [NOTE_W-1:0] FIRST_NOTE_RESET = 7'd36;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [NOTE_W-1:0]  note;
        logic [SLOT_W-1:0]  slot;
        logic [NSAMP_W-1:0] num_samples;
        logic [ACT_W-1:0]   stop_action;
        logic [LEN_W-1:0]   oneshot_samples;
        logic [MASK_W-1:0]  voice_active;
        logic [MASK_W-1:0]  voice_releasing;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] start_mask;
        logic [MASK_W-1:0] release_mask;
        logic [MASK_W-1:0] kill_mask;
        logic [SLOT_W-1:0] focus_slot;
        logic [MASK_W-1:0] latched_mask;
        logic [EXP_W-1:0]  next_expiry;
        logic              expiry_pending;
    } out_item_t;

endpackage

FILE: sv/pad_trigger_router_unit.sv
// ----------------------------------------------------------------------------
// pad_trigger_router_unit
// Turns pad requests into voice start/release/kill masks, with per-slot
// latch, preview, one-shot countdown and choke group handling.
//
//   channel   direction  handshake              beat
//   in        input      in_valid / in_ready    in_item   (ptr_pkg::in_item_t)
//   out       output     out_valid / out_ready  out_item  (ptr_pkg::out_item_t)
//   cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Takes one beat per cycle while the output is not stalled; a result passes
// through the input register, the middle stage (after the slot update) and
// the output register (after the expiry minimum). Slot state is updated as
// a beat leaves the input register, so the next beat sees it with no bubble.
// Reset clears all slot state and resets config at once; no clearing pass.
// A stalled output holds the pipeline; cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pad_trigger_router_unit_defines.svh"

module pad_trigger_router_unit #(
    parameter int NUM_SLOTS  = ptr_pkg::DEF_NUM_SLOTS,
    parameter int COUNT_BITS = ptr_pkg::DEF_COUNT_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ptr_pkg::in_item_t                  in_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ptr_pkg::out_item_t                 out_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ptr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW = COUNT_BITS;
    localparam int LW = (CW > ptr_pkg::LEN_W) ? CW : ptr_pkg::LEN_W;
    localparam int MW = (CW > ptr_pkg::NSAMP_W) ? CW : ptr_pkg::NSAMP_W;
    localparam int XW = (CW > ptr_pkg::EXP_W) ? CW : ptr_pkg::EXP_W;
    localparam int NG = (NUM_SLOTS + 3) / 4;

    // Configuration registers
    logic [ptr_pkg::NOTE_W-1:0]   first_note_reg;
    logic [ptr_pkg::MODES_W-1:0]  trigger_modes_reg;
    logic [ptr_pkg::GROUPS_W-1:0] choke_groups_reg;

    // Pipeline control
    logic in_valid_reg, mid_valid_reg, out_valid_reg;
    logic in_en, mid_en, out_en, fire;
    ptr_pkg::in_item_t  in_item_reg;
    ptr_pkg::out_item_t out_item_reg;

    // Slot state
    logic [NUM_SLOTS-1:0]        latched_reg, latched_next;
    logic [NUM_SLOTS-1:0]        preview_reg, preview_next;
    logic [NUM_SLOTS-1:0]        armed_reg, armed_next;
    logic [ptr_pkg::MODE_W-1:0]  smode_reg [NUM_SLOTS];
    logic [ptr_pkg::MODE_W-1:0]  smode_next [NUM_SLOTS];
    logic [CW-1:0]               cnt_reg [NUM_SLOTS];
    logic [CW-1:0]               cnt_next [NUM_SLOTS];
    logic [ptr_pkg::SLOT_W-1:0]  focus_reg, focus_next;

    // Slot stage results
    logic [NUM_SLOTS-1:0]        start_m, rel_m, kill_m;
    logic [CW-1:0]               gmin [NG];
    logic [NG-1:0]               gval;

    // Middle stage registers
    logic [NUM_SLOTS-1:0]        mid_start_reg, mid_rel_reg, mid_kill_reg, mid_latched_reg;
    logic [ptr_pkg::SLOT_W-1:0]  mid_focus_reg;
    logic [CW-1:0]               mid_gmin_reg [NG];
    logic [NG-1:0]               mid_gval_reg;

    // Expiry stage
    logic [CW-1:0]               best;
    logic                        best_val;
    logic [ptr_pkg::EXP_W-1:0]   best_sat;
    logic [NUM_SLOTS-1:0]        cnt_nz;

    // Handshake: each stage moves when the one after it can take a beat
    assign out_en    = !out_valid_reg || out_ready;
    assign mid_en    = !mid_valid_reg || out_en;
    assign in_en     = !in_valid_reg || mid_en;
    assign fire      = in_valid_reg && mid_en;
    assign in_ready  = in_en;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_note_reg    <= ptr_pkg::FIRST_NOTE_RESET;
            trigger_modes_reg <= '0;
            choke_groups_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ptr_pkg::CFG_FIRST_NOTE:
                    first_note_reg <= cfg_data[ptr_pkg::NOTE_W-1:0];
                ptr_pkg::CFG_TRIGGER_MODES:
                    trigger_modes_reg <= cfg_data[ptr_pkg::MODES_W-1:0];
                ptr_pkg::CFG_CHOKE_GROUPS:
                    choke_groups_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_en)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_en && in_valid)
            in_item_reg <= in_item;
    end

    // Slot update logic
    always_comb
    begin
        logic [NUM_SLOTS-1:0]         active, sounding, note_hit, slot_hit, is_latch;
        logic [NUM_SLOTS-1:0]         start_vec, choke;
        logic [ptr_pkg::MODE_W-1:0]   mode_v [NUM_SLOTS];
        logic [ptr_pkg::GROUP_W-1:0]  group_v [NUM_SLOTS];
        logic [ptr_pkg::NOTE_W-1:0]   diff;
        logic                         note_ge, toggle_off, starting, preview_start;
        logic [ptr_pkg::MODE_W-1:0]   start_mode, note_mode;
        logic [ptr_pkg::GROUP_W-1:0]  start_group;
        logic [LW-1:0]                len_w, len_c;
        logic [CW-1:0]                len_cnt;
        logic [ptr_pkg::REQ_W-1:0]    req;
        int                           idx;

        req      = in_item_reg.req_type;
        active   = in_item_reg.voice_active[NUM_SLOTS-1:0];
        sounding = active & ~in_item_reg.voice_releasing[NUM_SLOTS-1:0];
        note_ge  = in_item_reg.note >= first_note_reg;
        diff     = in_item_reg.note - first_note_reg;

        // Per-slot decode of config and target
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            mode_v[s]  = trigger_modes_reg[2*s +: 2];
            if (mode_v[s] == ptr_pkg::MODE_RESERVED)
                mode_v[s] = ptr_pkg::MODE_GATE;
            group_v[s]  = choke_groups_reg[4*s +: 4];
            is_latch[s] = (mode_v[s] == ptr_pkg::MODE_LATCH);
            note_hit[s] = note_ge && (diff == ptr_pkg::NOTE_W'(s));
            slot_hit[s] = (in_item_reg.slot == ptr_pkg::SLOT_W'(s));
        end

        // Which slot starts, in which mode, and its choke group
        toggle_off    = (req == ptr_pkg::REQ_NOTE_ON)
                        && (|(note_hit & is_latch & latched_reg & sounding));
        preview_start = (req == ptr_pkg::REQ_PREVIEW_ON);
        if ((req == ptr_pkg::REQ_NOTE_ON) && !toggle_off)
            start_vec = note_hit;
        else if (preview_start)
            start_vec = slot_hit;
        else
            start_vec = '0;
        starting    = |start_vec;
        note_mode   = '0;
        start_group = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (note_hit[s])
                note_mode = note_mode | mode_v[s];
            if (start_vec[s])
                start_group = start_group | group_v[s];
        end
        start_mode = preview_start ? ptr_pkg::MODE_GATE : note_mode;
        for (int s = 0; s < NUM_SLOTS; s++)
            choke[s] = starting && !start_vec[s] && (start_group != '0)
                       && (group_v[s] == start_group) && active[s];

        // One-shot length: at least 1, saturated to the counter width
        len_w = LW'(in_item_reg.oneshot_samples);
        if (len_w == '0)
            len_c = LW'(1);
        else if (len_w > LW'({CW{1'b1}}))
            len_c = LW'({CW{1'b1}});
        else
            len_c = len_w;
        len_cnt = CW'(len_c);

        latched_next = latched_reg;
        preview_next = preview_reg;
        armed_next   = armed_reg;
        smode_next   = smode_reg;
        cnt_next     = cnt_reg;
        start_m      = '0;
        rel_m        = '0;
        kill_m       = '0;

        // Per-slot request effects
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            unique case (req)
                ptr_pkg::REQ_NOTE_ON:
                begin
                    if (toggle_off && note_hit[s])
                    begin
                        latched_next[s] = 1'b0;
                        rel_m[s]        = 1'b1;
                    end
                end
                ptr_pkg::REQ_NOTE_OFF:
                begin
                    if (note_hit[s] && (smode_reg[s] == ptr_pkg::MODE_GATE)
                        && !preview_reg[s] && sounding[s])
                        rel_m[s] = 1'b1;
                end
                ptr_pkg::REQ_PREVIEW_OFF:
                begin
                    if (slot_hit[s] && preview_reg[s])
                    begin
                        preview_next[s] = 1'b0;
                        rel_m[s]        = sounding[s];
                    end
                end
                ptr_pkg::REQ_ADVANCE:
                begin
                    if (armed_reg[s])
                    begin
                        if (MW'(cnt_reg[s]) <= MW'(in_item_reg.num_samples))
                        begin
                            cnt_next[s]   = '0;
                            armed_next[s] = 1'b0;
                            rel_m[s]      = sounding[s];
                        end
                        else
                            cnt_next[s] = CW'(MW'(cnt_reg[s])
                                              - MW'(in_item_reg.num_samples));
                    end
                end
                ptr_pkg::REQ_STOP:
                begin
                    if (((in_item_reg.stop_action == ptr_pkg::STOP_KILL)
                         || (in_item_reg.stop_action == ptr_pkg::STOP_RELEASE))
                        && latched_reg[s])
                    begin
                        latched_next[s] = 1'b0;
                        if (in_item_reg.stop_action == ptr_pkg::STOP_KILL)
                            kill_m[s] = active[s];
                        else
                            rel_m[s] = sounding[s];
                    end
                end
                ptr_pkg::REQ_PANIC:
                begin
                    kill_m[s]       = active[s];
                    latched_next[s] = 1'b0;
                    preview_next[s] = 1'b0;
                    armed_next[s]   = 1'b0;
                    smode_next[s]   = ptr_pkg::MODE_GATE;
                    cnt_next[s]     = '0;
                end
                default:
                begin
                end
            endcase

            // Choke: other active slots of the started slot's group
            if (choke[s])
            begin
                kill_m[s]       = 1'b1;
                latched_next[s] = 1'b0;
                preview_next[s] = 1'b0;
                armed_next[s]   = 1'b0;
                smode_next[s]   = ptr_pkg::MODE_GATE;
                cnt_next[s]     = '0;
            end

            // Start of the target slot
            if (start_vec[s])
            begin
                start_m[s]      = 1'b1;
                smode_next[s]   = start_mode;
                latched_next[s] = (start_mode == ptr_pkg::MODE_LATCH);
                preview_next[s] = preview_start;
                armed_next[s]   = (start_mode == ptr_pkg::MODE_ONESHOT);
                cnt_next[s]     = (start_mode == ptr_pkg::MODE_ONESHOT) ? len_cnt : '0;
            end
        end

        // Focus follows starts, latch toggles and explicit requests
        focus_next = focus_reg;
        if ((req == ptr_pkg::REQ_NOTE_ON) && (|note_hit))
            focus_next = diff[ptr_pkg::SLOT_W-1:0];
        else if (((req == ptr_pkg::REQ_PREVIEW_ON) || (req == ptr_pkg::REQ_SET_FOCUS))
                 && (|slot_hit))
            focus_next = in_item_reg.slot;

        // Smallest armed countdown within each group of four slots
        for (int g = 0; g < NG; g++)
        begin
            gmin[g] = '0;
            gval[g] = 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                idx = 4 * g + k;
                if (idx < NUM_SLOTS)
                begin
                    if (armed_next[idx] && (!gval[g] || (cnt_next[idx] < gmin[g])))
                    begin
                        gmin[g] = cnt_next[idx];
                        gval[g] = 1'b1;
                    end
                end
            end
        end
    end

    // Slot state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_reg <= '0;
            preview_reg <= '0;
            armed_reg   <= '0;
            focus_reg   <= '0;
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                smode_reg[s] <= ptr_pkg::MODE_GATE;
                cnt_reg[s]   <= '0;
            end
        end
        else if (fire)
        begin
            latched_reg <= latched_next;
            preview_reg <= preview_next;
            armed_reg   <= armed_next;
            focus_reg   <= focus_next;
            smode_reg   <= smode_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Middle stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_valid_reg <= 1'b0;
        else if (mid_en)
            mid_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            mid_start_reg   <= start_m;
            mid_rel_reg     <= rel_m;
            mid_kill_reg    <= kill_m;
            mid_latched_reg <= latched_next;
            mid_focus_reg   <= focus_next;
            mid_gmin_reg    <= gmin;
            mid_gval_reg    <= gval;
        end
    end

    // Final minimum over the groups, saturated to the result width
    always_comb
    begin
        best     = '0;
        best_val = 1'b0;
        for (int g = 0; g < NG; g++)
        begin
            if (mid_gval_reg[g] && (!best_val || (mid_gmin_reg[g] < best)))
            begin
                best     = mid_gmin_reg[g];
                best_val = 1'b1;
            end
        end
        if (!best_val)
            best_sat = '0;
        else if (XW'(best) > XW'({ptr_pkg::EXP_W{1'b1}}))
            best_sat = '1;
        else
            best_sat = ptr_pkg::EXP_W'(XW'(best));
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= mid_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && mid_valid_reg)
        begin
            out_item_reg.start_mask     <= ptr_pkg::MASK_W'(mid_start_reg);
            out_item_reg.release_mask   <= ptr_pkg::MASK_W'(mid_rel_reg);
            out_item_reg.kill_mask      <= ptr_pkg::MASK_W'(mid_kill_reg);
            out_item_reg.focus_slot     <= mid_focus_reg;
            out_item_reg.latched_mask   <= ptr_pkg::MASK_W'(mid_latched_reg);
            out_item_reg.next_expiry    <= best_sat;
            out_item_reg.expiry_pending <= best_val;
        end
    end

    // Nonzero flag per countdown, for checking
    always_comb
    begin
        for (int s = 0; s < NUM_SLOTS; s++)
            cnt_nz[s] = (cnt_reg[s] != '0);
    end

    // Checks
    `PTR_ASSERT_IMPL(a_armed_nonzero, 1'b1, (armed_reg & ~cnt_nz) == '0, "armed countdown at zero")
    `PTR_ASSERT_IMPL(a_start_disjoint, out_valid_reg, ((out_item_reg.start_mask & out_item_reg.kill_mask) == '0) && ((out_item_reg.start_mask & out_item_reg.release_mask) == '0), "start overlaps kill or release")
    `PTR_ASSERT_IMPL(a_single_start, out_valid_reg, $countones(out_item_reg.start_mask) <= 1, "more than one slot started")
    `PTR_ASSERT_IMPL(a_expiry_idle, out_valid_reg && !out_item_reg.expiry_pending, out_item_reg.next_expiry == '0, "expiry value without pending countdown")
    `PTR_ASSERT_NEXT(a_panic_clears, fire && (in_item_reg.req_type == ptr_pkg::REQ_PANIC), (latched_reg == '0) && (armed_reg == '0) && (preview_reg == '0), "panic left slot state")

endmodule

FILE: tb/tb_pad_trigger_router_unit.sv
// ----------------------------------------------------------------------------
// tb_pad_trigger_router_unit
// Self-checking bench for the pad trigger router. A queue of pad requests
// feeds a valid/ready driver, and a clocked monitor predicts the voice
// commands for every accepted beat and compares each result beat with the
// oldest prediction. The run covers several register settings, a directed
// sequence over the trigger modes and choke groups, and random traffic with
// random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pad_trigger_router_unit;

    import ptr_pkg::*;

    localparam int NSLOT         = DEF_NUM_SLOTS;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;

    // Stop actions the package leaves unnamed
    localparam logic [ACT_W-1:0] STOP_CONTINUE = 2'd0;
    localparam logic [ACT_W-1:0] STOP_UNUSED   = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_style_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pad_trigger_router_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Bench bookkeeping
    in_item_t    queued_requests[$];
    out_item_t   expected_cmds[$];
    idle_style_t idle_style = IDLE_FULL;
    int          n_in_accepted = 0;
    int          n_out_accepted = 0;
    int          n_cfg_writes = 0;
    int          mismatches = 0;
    int          n_starts = 0;
    int          n_releases = 0;
    int          n_kills = 0;
    int          n_expiring = 0;

    // Predictor copy of the registers and per-slot state
    logic [NOTE_W-1:0]   cur_first_note;
    logic [MODES_W-1:0]  cur_modes;
    logic [GROUPS_W-1:0] cur_groups;
    logic [NSLOT-1:0]    latch_bits;
    logic [NSLOT-1:0]    preview_bits;
    logic [NSLOT-1:0]    armed_bits;
    logic [MODE_W-1:0]   began_mode [NSLOT];
    logic [LEN_W-1:0]    remaining [NSLOT];
    logic [SLOT_W-1:0]   focus_now;

    function automatic logic [MODE_W-1:0] mode_of(input int s);
        logic [MODE_W-1:0] m;
        m = cur_modes[2*s +: 2];
        return (m == MODE_RESERVED) ? MODE_GATE : m;
    endfunction

    function automatic logic [GROUP_W-1:0] group_of(input int s);
        return cur_groups[4*s +: 4];
    endfunction

    function automatic void clear_slot_state(input int s);
        latch_bits[s]   = 1'b0;
        preview_bits[s] = 1'b0;
        armed_bits[s]   = 1'b0;
        began_mode[s]   = MODE_GATE;
        remaining[s]    = '0;
    endfunction

    // Start slot s; returns the slots choked by its group
    function automatic logic [NSLOT-1:0] trigger_slot(input int s,
                                                      input logic [MODE_W-1:0] mode,
                                                      input logic [LEN_W-1:0] len,
                                                      input logic [NSLOT-1:0] active);
        logic [NSLOT-1:0]   choked;
        logic [GROUP_W-1:0] g;
        int                 k;
        choked = '0;
        g = group_of(s);
        if (g != 0)
        begin
            for (k = 0; k < NSLOT; k++)
            begin
                if (k != s && group_of(k) == g && active[k])
                begin
                    choked[k] = 1'b1;
                    clear_slot_state(k);
                end
            end
        end
        focus_now       = SLOT_W'(s);
        began_mode[s]   = mode;
        latch_bits[s]   = (mode == MODE_LATCH);
        preview_bits[s] = 1'b0;
        if (mode == MODE_ONESHOT)
        begin
            remaining[s]  = (len == 0) ? LEN_W'(1) : len;
            armed_bits[s] = 1'b1;
        end
        else
        begin
            remaining[s]  = '0;
            armed_bits[s] = 1'b0;
        end
        return choked;
    endfunction

    // Voice commands caused by one request; updates the predictor state
    function automatic out_item_t compute_voice_cmds(input in_item_t rq);
        out_item_t        r;
        logic [NSLOT-1:0] sounding;
        logic [NSLOT-1:0] start_m;
        logic [NSLOT-1:0] rel_m;
        logic [NSLOT-1:0] kill_m;
        logic [LEN_W-1:0] best;
        logic             pending;
        logic             note_ok;
        int               nd;
        int               ns;
        int               k;
        sounding = rq.voice_active & ~rq.voice_releasing;
        start_m  = '0;
        rel_m    = '0;
        kill_m   = '0;
        nd = int'(rq.note) - int'(cur_first_note);
        note_ok = (nd >= 0) && (nd < NSLOT);
        ns = note_ok ? nd : 0;

        case (rq.req_type)
            REQ_NOTE_ON:
            begin
                if (note_ok)
                begin
                    // latched slot that still sounds toggles off
                    if (mode_of(ns) == MODE_LATCH && latch_bits[ns] && sounding[ns])
                    begin
                        rel_m[ns]      = 1'b1;
                        latch_bits[ns] = 1'b0;
                        focus_now      = SLOT_W'(ns);
                    end
                    else
                    begin
                        kill_m = kill_m | trigger_slot(ns, mode_of(ns),
                                                       rq.oneshot_samples, rq.voice_active);
                        start_m[ns] = 1'b1;
                    end
                end
            end
            REQ_NOTE_OFF:
            begin
                if (note_ok && began_mode[ns] == MODE_GATE && !preview_bits[ns] &&
                    sounding[ns])
                    rel_m[ns] = 1'b1;
            end
            REQ_PREVIEW_ON:
            begin
                kill_m = kill_m | trigger_slot(rq.slot, MODE_GATE, rq.oneshot_samples,
                                               rq.voice_active);
                start_m[rq.slot]      = 1'b1;
                preview_bits[rq.slot] = 1'b1;
            end
            REQ_PREVIEW_OFF:
            begin
                if (preview_bits[rq.slot])
                begin
                    preview_bits[rq.slot] = 1'b0;
                    if (sounding[rq.slot])
                        rel_m[rq.slot] = 1'b1;
                end
            end
            REQ_ADVANCE:
            begin
                for (k = 0; k < NSLOT; k++)
                begin
                    if (armed_bits[k])
                    begin
                        if (remaining[k] <= LEN_W'(rq.num_samples))
                        begin
                            remaining[k]  = '0;
                            armed_bits[k] = 1'b0;
                            if (sounding[k])
                                rel_m[k] = 1'b1;
                        end
                        else
                            remaining[k] = remaining[k] - LEN_W'(rq.num_samples);
                    end
                end
            end
            REQ_STOP:
            begin
                if (rq.stop_action == STOP_KILL || rq.stop_action == STOP_RELEASE)
                begin
                    for (k = 0; k < NSLOT; k++)
                    begin
                        if (latch_bits[k])
                        begin
                            latch_bits[k] = 1'b0;
                            if (rq.voice_active[k])
                            begin
                                if (rq.stop_action == STOP_KILL)
                                    kill_m[k] = 1'b1;
                                else if (sounding[k])
                                    rel_m[k] = 1'b1;
                            end
                        end
                    end
                end
            end
            REQ_PANIC:
            begin
                kill_m = rq.voice_active;
                for (k = 0; k < NSLOT; k++)
                    clear_slot_state(k);
            end
            default:
                focus_now = rq.slot;
        endcase

        // nearest running countdown
        pending = 1'b0;
        best    = '0;
        for (k = 0; k < NSLOT; k++)
        begin
            if (armed_bits[k] && (!pending || remaining[k] < best))
            begin
                best    = remaining[k];
                pending = 1'b1;
            end
        end

        r.start_mask     = start_m;
        r.release_mask   = rel_m;
        r.kill_mask      = kill_m;
        r.focus_slot     = focus_now;
        r.latched_mask   = latch_bits;
        r.next_expiry    = pending ? best : '0;
        r.expiry_pending = pending;
        return r;
    endfunction

    function automatic int draw_gap();
        case (idle_style)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 18)) : 0;
            default:    return int'($urandom_range(0, 18));
        endcase
    endfunction

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d %s: expected %h, got %h",
                         n_out_accepted, fname, want, got);
        end
    endtask

    // Request driver: presents queued beats, idles between them
    int in_seen = 0;
    int send_gap = 0;

    always @(negedge clk)
    begin : request_driver
        if (rst_n)
        begin
            if (!(in_valid && n_in_accepted == in_seen))
            begin
                in_seen = n_in_accepted;
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (queued_requests.size() != 0)
                begin
                    in_item  <= queued_requests.pop_front();
                    in_valid <= 1'b1;
                    send_gap = draw_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls a random number of cycles after each beat
    int out_seen = 0;
    int recv_stall = 0;

    always @(negedge clk)
    begin : result_receiver
        if (rst_n)
        begin
            if (n_out_accepted != out_seen)
            begin
                out_seen   = n_out_accepted;
                recv_stall = draw_gap();
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: predict on request beats, check result beats
    always @(posedge clk)
    begin : cmd_monitor
        out_item_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_cmds.push_back(compute_voice_cmds(in_item));
                n_in_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_cmds.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with nothing expected", n_out_accepted);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    check_field("start_mask", want.start_mask, out_item.start_mask);
                    check_field("release_mask", want.release_mask, out_item.release_mask);
                    check_field("kill_mask", want.kill_mask, out_item.kill_mask);
                    check_field("focus_slot", want.focus_slot, out_item.focus_slot);
                    check_field("latched_mask", want.latched_mask, out_item.latched_mask);
                    check_field("next_expiry", want.next_expiry, out_item.next_expiry);
                    check_field("expiry_pending", want.expiry_pending,
                                out_item.expiry_pending);
                    if (want.start_mask != 0)
                        n_starts++;
                    if (want.release_mask != 0)
                        n_releases++;
                    if (want.kill_mask != 0)
                        n_kills++;
                    if (want.expiry_pending)
                        n_expiring++;
                end
                n_out_accepted++;
            end
        end
    end

    // Watchdog: ends the run after a long stretch with no beat anywhere
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_pad_trigger_router_unit: errors");
        $finish;
    end

    // Wait until every request is sent and every result has come back
    task automatic wait_idle();
        while (!(queued_requests.size() == 0 && !in_valid && expected_cmds.size() == 0))
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_FIRST_NOTE:    cur_first_note = data[NOTE_W-1:0];
            CFG_TRIGGER_MODES: cur_modes      = data[MODES_W-1:0];
            CFG_CHOKE_GROUPS:  cur_groups     = data;
            default: ;
        endcase
        n_cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_req(input logic [REQ_W-1:0] req, input int note, input int slot,
                            input int nsamp, input logic [ACT_W-1:0] act, input int len,
                            input logic [MASK_W-1:0] active,
                            input logic [MASK_W-1:0] rel);
        in_item_t rq;
        rq.req_type        = req;
        rq.note            = NOTE_W'(note);
        rq.slot            = SLOT_W'(slot);
        rq.num_samples     = NSAMP_W'(nsamp);
        rq.stop_action     = act;
        rq.oneshot_samples = LEN_W'(len);
        rq.voice_active    = active;
        rq.voice_releasing = rel;
        queued_requests.push_back(rq);
    endtask

    // Random request, notes mostly on the pads of the current mapping
    function automatic in_item_t make_random_request();
        in_item_t rq;
        int       pick;
        int       nn;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            rq.req_type = REQ_NOTE_ON;
        else if (pick < 45)
            rq.req_type = REQ_NOTE_OFF;
        else if (pick < 55)
            rq.req_type = REQ_PREVIEW_ON;
        else if (pick < 64)
            rq.req_type = REQ_PREVIEW_OFF;
        else if (pick < 82)
            rq.req_type = REQ_ADVANCE;
        else if (pick < 88)
            rq.req_type = REQ_STOP;
        else if (pick < 91)
            rq.req_type = REQ_PANIC;
        else
            rq.req_type = REQ_SET_FOCUS;

        nn = int'(cur_first_note) + int'($urandom_range(0, NSLOT - 1));
        if ($urandom_range(0, 4) == 0 || nn > 127)
            nn = $urandom_range(0, 127);
        rq.note = NOTE_W'(nn);
        rq.slot = SLOT_W'($urandom_range(0, NSLOT - 1));
        rq.num_samples = ($urandom_range(0, 3) == 0) ? NSAMP_W'($urandom)
                                                      : NSAMP_W'($urandom_range(0, 3000));
        rq.stop_action = ACT_W'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0:       rq.oneshot_samples = '0;
            1:       rq.oneshot_samples = LEN_W'($urandom);
            default: rq.oneshot_samples = LEN_W'($urandom_range(1, 6000));
        endcase
        case ($urandom_range(0, 3))
            0:       rq.voice_active = MASK_W'($urandom);
            1:       rq.voice_active = '1;
            2:       rq.voice_active = MASK_W'($urandom | $urandom);
            default: rq.voice_active = MASK_W'($urandom & $urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       rq.voice_releasing = MASK_W'($urandom);
            1:       rq.voice_releasing = '0;
            default: rq.voice_releasing = MASK_W'($urandom & $urandom & $urandom);
        endcase
        return rq;
    endfunction

    // Random traffic, with a full drain halfway through
    task automatic push_random(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            queued_requests.push_back(make_random_request());
            if (i == count / 2)
                wait_idle();
        end
    endtask

    // One register setting followed by random traffic
    task automatic run_phase(input logic [NOTE_W-1:0] fnote,
                             input logic [MODES_W-1:0] modes,
                             input logic [GROUPS_W-1:0] groups,
                             input idle_style_t style, input int count);
        wait_idle();
        write_reg(CFG_FIRST_NOTE, CFG_DATA_W'(fnote));
        write_reg(CFG_TRIGGER_MODES, CFG_DATA_W'(modes));
        write_reg(CFG_CHOKE_GROUPS, groups);
        idle_style = style;
        push_random(count);
    endtask

    // Main sequence
    initial
    begin : main_seq
        int                  k;
        int                  leftover;
        logic [GROUPS_W-1:0] few_groups;

        cur_first_note = FIRST_NOTE_RESET;
        cur_modes      = '0;
        cur_groups     = '0;
        focus_now      = '0;
        for (k = 0; k < NSLOT; k++)
            clear_slot_state(k);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values of the registers
        idle_style = IDLE_FULL;
        push_random(40);

        // directed: slot s runs mode s%4; groups 1,2,none,15 by quarter
        wait_idle();
        write_reg(CFG_FIRST_NOTE, CFG_DATA_W'(36));
        write_reg(CFG_TRIGGER_MODES, CFG_DATA_W'(32'hE4E4_E4E4));
        write_reg(CFG_CHOKE_GROUPS, 64'hFFFF_0000_2222_1111);
        idle_style = IDLE_LIGHT;
        push_req(REQ_NOTE_ON,     36,  0, 0,     STOP_CONTINUE, 100,       16'h0000, 16'h0000);
        push_req(REQ_NOTE_ON,     37,  0, 0,     STOP_CONTINUE, 100,       16'h0001, 16'h0000);
        push_req(REQ_NOTE_ON,     37,  0, 0,     STOP_CONTINUE, 100,       16'h0002, 16'h0000);
        push_req(REQ_NOTE_ON,     38,  0, 0,     STOP_CONTINUE, 0,         16'h0000, 16'h0000);
        push_req(REQ_NOTE_ON,     42,  0, 0,     STOP_CONTINUE, 24'hFFFFFF, 16'h0000, 16'h0000);
        push_req(REQ_NOTE_ON,     39,  0, 0,     STOP_CONTINUE, 100,       16'h004F, 16'h0000);
        push_req(REQ_NOTE_ON,     35,  0, 0,     STOP_CONTINUE, 100,       16'hFFFF, 16'h0000);
        push_req(REQ_NOTE_ON,     52,  0, 0,     STOP_CONTINUE, 100,       16'hFFFF, 16'h0000);
        push_req(REQ_NOTE_ON,     51,  0, 0,     STOP_CONTINUE, 100,       16'hF000, 16'h0000);
        push_req(REQ_NOTE_ON,     127, 0, 0,     STOP_CONTINUE, 100,       16'hFFFF, 16'h0000);
        push_req(REQ_NOTE_OFF,    51,  0, 0,     STOP_CONTINUE, 0,         16'hFFFF, 16'h0000);
        push_req(REQ_NOTE_OFF,    51,  0, 0,     STOP_CONTINUE, 0,         16'hFFFF, 16'hFFFF);
        push_req(REQ_PREVIEW_ON,  0,   5, 0,     STOP_CONTINUE, 0,         16'hFFFF, 16'h0000);
        push_req(REQ_NOTE_OFF,    41,  0, 0,     STOP_CONTINUE, 0,         16'hFFFF, 16'h0000);
        push_req(REQ_PREVIEW_OFF, 0,   5, 0,     STOP_CONTINUE, 0,         16'h0020, 16'h0000);
        push_req(REQ_PREVIEW_OFF, 0,   5, 0,     STOP_CONTINUE, 0,         16'h0020, 16'h0000);
        push_req(REQ_NOTE_ON,     38,  0, 0,     STOP_CONTINUE, 5,         16'h0000, 16'h0000);
        push_req(REQ_ADVANCE,     0,   0, 0,     STOP_CONTINUE, 0,         16'hFFFF, 16'h0000);
        push_req(REQ_ADVANCE,     0,   0, 65535, STOP_CONTINUE, 0,         16'h0004, 16'h0000);
        push_req(REQ_NOTE_ON,     41,  0, 0,     STOP_CONTINUE, 0,         16'h0000, 16'h0000);
        push_req(REQ_STOP,        0,   0, 0,     STOP_CONTINUE, 0,         16'hFFFF, 16'h0000);
        push_req(REQ_STOP,        0,   0, 0,     STOP_UNUSED,   0,         16'hFFFF, 16'h0000);
        push_req(REQ_STOP,        0,   0, 0,     STOP_KILL,     0,         16'hFFFF, 16'h0000);
        push_req(REQ_NOTE_ON,     41,  0, 0,     STOP_CONTINUE, 0,         16'h0000, 16'h0000);
        push_req(REQ_STOP,        0,   0, 0,     STOP_RELEASE,  0,         16'hFFFF, 16'h0000);
        push_req(REQ_PANIC,       0,   0, 0,     STOP_CONTINUE, 0,         16'hFFFF, 16'h0000);
        push_req(REQ_SET_FOCUS,   0,  15, 0,     STOP_CONTINUE, 0,         16'h0000, 16'h0000);
        push_req(REQ_SET_FOCUS,   0,   0, 0,     STOP_CONTINUE, 0,         16'h0000, 16'h0000);

        // random phases over several register settings
        run_phase(7'd0, 32'h0000_0000, {$urandom, $urandom}, IDLE_FULL, 95);
        run_phase(7'd100, 32'hAAAA_AAAA, 64'h0, IDLE_NONE, 95);
        run_phase(7'd127, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, IDLE_LIGHT, 70);
        run_phase(NOTE_W'($urandom_range(0, 112)), 32'h5555_5555,
                  64'h1111_1111_1111_1111, IDLE_FULL, 95);
        few_groups = '0;
        for (k = 0; k < NSLOT; k++)
            few_groups[4*k +: 4] = GROUP_W'($urandom_range(0, 3));
        run_phase(7'd112, MODES_W'($urandom), few_groups, IDLE_LIGHT, 95);

        wait_idle();
        leftover = expected_cmds.size();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);

        $display("%0d requests over %0d register writes, %0d results checked, %0d mismatches",
                 n_in_accepted, n_cfg_writes, n_out_accepted, mismatches);
        $display("results with starts %0d, releases %0d, kills %0d, countdown running %0d",
                 n_starts, n_releases, n_kills, n_expiring);
        if (mismatches == 0 && leftover == 0)
            $display("tb_pad_trigger_router_unit: clean");
        else
            $display("tb_pad_trigger_router_unit: errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/ptr_pkg.sv
sv/pad_trigger_router_unit.sv
tb/tb_pad_trigger_router_unit.sv
